// ===== rtl/pid_pkg.sv =====
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types and constants for the positional PID controller.
// ----------------------------------------------------------------------------
package pid_pkg;

    localparam int DATA_W    = 32;
    localparam int PERIOD_W  = 31;
    localparam int REG_IDX_W = 3;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    // Configuration register reset values
    localparam logic signed [DATA_W-1:0]   RST_KP      = 32'sd78643;
    localparam logic signed [DATA_W-1:0]   RST_KI      = 32'sd22938;
    localparam logic signed [DATA_W-1:0]   RST_KD      = 32'sd5243;
    localparam logic        [PERIOD_W-1:0] RST_PERIOD  = 31'd6554;
    localparam logic signed [DATA_W-1:0]   RST_IFLOOR  = -32'sd1310720;
    localparam logic signed [DATA_W-1:0]   RST_ICEIL   = 32'sd1310720;
    localparam logic signed [DATA_W-1:0]   RST_OFLOOR  = 32'sd0;
    localparam logic signed [DATA_W-1:0]   RST_OCEIL   = 32'sd6553600;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KP      = 3'd0,
        REG_KI      = 3'd1,
        REG_KD      = 3'd2,
        REG_PERIOD  = 3'd3,
        REG_IFLOOR  = 3'd4,
        REG_ICEIL   = 3'd5,
        REG_OFLOOR  = 3'd6,
        REG_OCEIL   = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_INC,
        S_PROP,
        S_ILIM,
        S_IMUL,
        S_IACC,
        S_DWAIT,
        S_DACC,
        S_CLAMP
    } t_state;

    // Divider handshake
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== rtl/pid_mul.sv =====
// ----------------------------------------------------------------------------
// pid_mul
// Shared 32x32 signed multiplier with registered product, followed by an
// arithmetic right shift by the fraction width and saturation to 32 bits.
// ----------------------------------------------------------------------------
module pid_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic signed [pid_pkg::DATA_W-1:0]   i_a,
    input  logic signed [pid_pkg::DATA_W-1:0]   i_b,
    output logic signed [pid_pkg::DATA_W-1:0]   o_res
);
    import pid_pkg::*;

    localparam int PROD_W = 2 * DATA_W;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] shifted;
    logic                     fits;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Floor shift, then saturate when the upper bits are not a sign extension
    assign shifted = r_prod >>> FRAC_BITS;
    assign fits    = (&shifted[PROD_W-1:DATA_W-1]) | ~(|shifted[PROD_W-1:DATA_W-1]);

    always_comb begin
        if (fits) begin
            o_res = shifted[DATA_W-1:0];
        end else if (shifted[PROD_W-1]) begin
            o_res = SAT_MIN;
        end else begin
            o_res = SAT_MAX;
        end
    end

endmodule

// ===== rtl/pid_div.sv =====
// ----------------------------------------------------------------------------
// pid_div
// Bit-serial restoring divider for the derivative term: (diff << FRAC_BITS)
// divided by the sample period, truncated toward zero, saturated to 32 bits.
// ----------------------------------------------------------------------------
module pid_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pid_pkg::t_div_ctl                   i_ctl,
    input  logic signed [pid_pkg::DATA_W:0]     i_diff,
    input  logic        [pid_pkg::PERIOD_W-1:0] i_period,
    output pid_pkg::t_div_sts                   o_sts,
    output logic signed [pid_pkg::DATA_W-1:0]   o_quot
);
    import pid_pkg::*;

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [NW-1:0]        r_num;
    logic [PERIOD_W-1:0]  r_rem;
    logic [PERIOD_W-1:0]  r_div;
    logic [CW-1:0]        r_cnt;
    logic                 r_neg;
    logic                 r_zero_div;
    logic                 r_zero_diff;

    logic [DATA_W:0]      diff_abs;
    logic [DATA_W-1:0]    trial;
    logic [DATA_W-1:0]    trial_sub;
    logic                 ge;
    logic                 ovf_pos;
    logic                 ovf_neg;

    assign diff_abs  = i_diff[DATA_W] ? (~i_diff + 33'd1) : i_diff;
    assign trial     = {r_rem, r_num[NW-1]};
    assign trial_sub = trial - {1'b0, r_div};
    assign ge        = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_zero_div || r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num       <= {diff_abs[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            r_rem       <= '0;
            r_div       <= i_period;
            r_neg       <= i_diff[DATA_W];
            r_zero_div  <= (i_period == '0);
            r_zero_diff <= (i_diff == '0);
        end else if (r_busy) begin
            // One quotient bit per cycle, shifted into the numerator register
            r_num <= {r_num[NW-2:0], ge};
            r_rem <= ge ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        end
    end

    assign ovf_pos = |r_num[NW-1:DATA_W-1];
    assign ovf_neg = (|r_num[NW-1:DATA_W]) | (r_num[DATA_W-1] & (|r_num[DATA_W-2:0]));

    always_comb begin
        if (r_zero_div) begin
            if (r_zero_diff) begin
                o_quot = '0;
            end else if (r_neg) begin
                o_quot = SAT_MIN;
            end else begin
                o_quot = SAT_MAX;
            end
        end else if (r_neg) begin
            o_quot = ovf_neg ? SAT_MIN : signed'(~r_num[DATA_W-1:0] + 32'd1);
        end else begin
            o_quot = ovf_pos ? SAT_MAX : signed'(r_num[DATA_W-1:0]);
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// ===== rtl/positional_pid_controller.sv =====
// ----------------------------------------------------------------------------
// positional_pid_controller
// Positional PID controller with anti-windup in signed fixed point. A small
// sequencer drives one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// Sequence: an accepted item steps through S_ERR, S_INC, S_PROP, S_ILIM, S_IMUL,
// S_IACC, S_DWAIT (held until the serial divider is done, early on a zero period),
// S_DACC and S_CLAMP. A new item is taken only in S_IDLE, once the result has been
// loaded into the output register, which waits while the output is not taken.
// Reset (synchronous, active low) loads the register defaults and clears the
// integral, the last error and the output valid.
// ----------------------------------------------------------------------------
module positional_pid_controller #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: target_value [31:0], measured_value [63:32]
    input  logic [2*pid_pkg::DATA_W-1:0]         s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: drive_value [31:0]
    output logic [pid_pkg::DATA_W-1:0]           m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_we,
    input  logic [pid_pkg::REG_IDX_W-1:0]        i_cfg_addr,
    input  logic [pid_pkg::DATA_W-1:0]           i_cfg_wdata
);
    import pid_pkg::*;

    localparam int ACC_W = DATA_W + 2;

    // Configuration
    logic signed [DATA_W-1:0]   r_kp, r_ki, r_kd;
    logic        [PERIOD_W-1:0] r_period;
    logic signed [DATA_W-1:0]   r_ifloor, r_iceil, r_ofloor, r_oceil;

    // Sequencer and datapath
    t_state                     r_state, n_state;
    logic signed [DATA_W-1:0]   r_target, r_meas;
    logic signed [DATA_W-1:0]   r_err;
    logic signed [DATA_W-1:0]   r_last_err;
    logic signed [DATA_W-1:0]   r_integ;
    logic signed [DATA_W-1:0]   r_isum;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [DATA_W-1:0]   r_out;
    logic                       r_out_valid;

    logic signed [DATA_W:0]     err_wide;
    logic signed [DATA_W:0]     isum_wide;
    logic signed [DATA_W:0]     diff;
    logic signed [DATA_W-1:0]   mul_a, mul_b, mul_res;
    logic signed [DATA_W-1:0]   div_quot;
    logic signed [DATA_W-1:0]   drive;
    t_div_ctl                   div_ctl;
    t_div_sts                   div_sts;
    logic                       out_load;
    logic                       in_accept;

    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1]) begin
            return v[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        return v[DATA_W-1:0];
    endfunction

    // Floor is checked first; with crossed limits, values below the floor get the floor, all others the ceiling
    function automatic logic signed [DATA_W-1:0] clamp(input logic signed [ACC_W-1:0] v,
                                                       input logic signed [DATA_W-1:0] lo,
                                                       input logic signed [DATA_W-1:0] hi);
        if (v < ACC_W'(lo)) begin
            return lo;
        end
        if (v > ACC_W'(hi)) begin
            return hi;
        end
        return v[DATA_W-1:0];
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= RST_KP;
            r_ki     <= RST_KI;
            r_kd     <= RST_KD;
            r_period <= RST_PERIOD;
            r_ifloor <= RST_IFLOOR;
            r_iceil  <= RST_ICEIL;
            r_ofloor <= RST_OFLOOR;
            r_oceil  <= RST_OCEIL;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_KP:     r_kp     <= signed'(i_cfg_wdata);
                REG_KI:     r_ki     <= signed'(i_cfg_wdata);
                REG_KD:     r_kd     <= signed'(i_cfg_wdata);
                REG_PERIOD: r_period <= i_cfg_wdata[PERIOD_W-1:0];
                REG_IFLOOR: r_ifloor <= signed'(i_cfg_wdata);
                REG_ICEIL:  r_iceil  <= signed'(i_cfg_wdata);
                REG_OFLOOR: r_ofloor <= signed'(i_cfg_wdata);
                REG_OCEIL:  r_oceil  <= signed'(i_cfg_wdata);
                default:    r_kp     <= r_kp;
            endcase
        end
    end

    // ---------------- shared units ----------------
    pid_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_res (mul_res)
    );

    pid_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (div_ctl),
        .i_diff   (diff),
        .i_period (r_period),
        .o_sts    (div_sts),
        .o_quot   (div_quot)
    );

    // ---------------- sequencer ----------------
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_load  = (r_state == S_CLAMP) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_ERR;
            S_ERR:   n_state = S_INC;
            S_INC:   n_state = S_PROP;
            S_PROP:  n_state = S_ILIM;
            S_ILIM:  n_state = S_IMUL;
            S_IMUL:  n_state = S_IACC;
            S_IACC:  n_state = S_DWAIT;
            S_DWAIT: if (div_sts.done) n_state = S_DACC;
            S_DACC:  n_state = S_CLAMP;
            S_CLAMP: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        div_ctl.start = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_INC: begin
                mul_a         = r_err;
                mul_b         = signed'({1'b0, r_period});
                div_ctl.start = 1'b1;
            end
            S_PROP: begin
                mul_a = r_kp;
                mul_b = r_err;
            end
            S_IMUL: begin
                mul_a = r_ki;
                mul_b = r_integ;
            end
            S_DWAIT: begin
                mul_a = r_kd;
                mul_b = div_quot;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // ---------------- datapath ----------------
    assign err_wide  = {r_target[DATA_W-1], r_target} - {r_meas[DATA_W-1], r_meas};
    assign diff      = {r_err[DATA_W-1], r_err} - {r_last_err[DATA_W-1], r_last_err};
    assign isum_wide = {r_integ[DATA_W-1], r_integ} + {mul_res[DATA_W-1], mul_res};
    assign drive     = clamp(r_acc, r_ofloor, r_oceil);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
            r_integ    <= '0;
        end else begin
            if (r_state == S_INC) begin
                r_last_err <= r_err;
            end
            if (r_state == S_ILIM) begin
                r_integ <= clamp(ACC_W'(r_isum), r_ifloor, r_iceil);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_target <= signed'(s_axis_tdata[DATA_W-1:0]);
            r_meas   <= signed'(s_axis_tdata[2*DATA_W-1:DATA_W]);
        end
        if (r_state == S_ERR) begin
            r_err <= sat33(err_wide);
        end
        if (r_state == S_PROP) begin
            r_isum <= sat33(isum_wide);
        end
        unique case (r_state)
            S_ILIM:  r_acc <= ACC_W'(mul_res);
            S_IACC:  r_acc <= r_acc + ACC_W'(mul_res);
            S_DACC:  r_acc <= r_acc + ACC_W'(mul_res);
            default: r_acc <= r_acc;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= drive;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // ---------------- assertions ----------------
    a_dterm_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DACC) |-> $past(div_sts.done))
        else $error("derivative term issued before divider finished");

    a_div_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_sts.busy)
        else $error("divider busy while accepting a new item");

    a_integ_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IMUL) && ($past(r_ifloor) <= $past(r_iceil))) |->
        ((r_integ >= $past(r_ifloor)) && (r_integ <= $past(r_iceil))))
        else $error("integral outside its limits");

    a_drive_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_ofloor <= r_oceil)) |=>
        ((signed'(m_axis_tdata) >= $past(r_ofloor)) &&
         (signed'(m_axis_tdata) <= $past(r_oceil))))
        else $error("drive value outside output limits");

endmodule
